### src/sled_pkg.sv
// ----------------------------------------------------------------------------
// sled_pkg
// shared types and codes of the string literal escape decoder
// ----------------------------------------------------------------------------
package sled_pkg;

  localparam int unsigned MaxRes = 4;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ERR  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // error codes
  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_UTF8     = 4'd1;
  localparam logic [3:0] ERR_ESCAPE   = 4'd2;
  localparam logic [3:0] ERR_OCT_DIG  = 4'd3;
  localparam logic [3:0] ERR_OCT_OVER = 4'd4;
  localparam logic [3:0] ERR_HEX_DIG  = 4'd5;
  localparam logic [3:0] ERR_SHORT_U4 = 4'd6;
  localparam logic [3:0] ERR_SHORT_U8 = 4'd7;
  localparam logic [3:0] ERR_RANGE    = 4'd8;
  localparam logic [3:0] ERR_UNFIN    = 4'd9;

  localparam logic [20:0] CpMax = 21'h10FFFF;

  typedef enum logic [6:0] {
    MODE_PLAIN = 7'b0000001,
    MODE_ESC   = 7'b0000010,
    MODE_OCT   = 7'b0000100,
    MODE_HEXX  = 7'b0001000,
    MODE_UNI4  = 7'b0010000,
    MODE_UNI8  = 7'b0100000,
    MODE_UTF8  = 7'b1000000
  } mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_literal;
  } in_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [3:0] error_code;
    logic       literal_failed;
    logic       last_of_run;
  } out_t;

  // all results caused by one item
  typedef struct packed {
    logic [2:0]           cnt;
    out_t [MaxRes-1:0]    slot;
  } run_t;

endpackage

### src/sled_core.sv
// ----------------------------------------------------------------------------
// sled_core
// decode state and per-item result generation
// ----------------------------------------------------------------------------
module sled_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  sled_pkg::in_t  item_i,
  output sled_pkg::run_t run_o
);

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } enc_t;

  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t e;
    e.b = '0;
    if (cp <= 21'h7F) begin
      e.n    = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      e.n    = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      e.n    = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.n    = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_of(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(b - 8'h41 + 8'd10)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(b - 8'h61 + 8'd10)};
    end
    return r;
  endfunction

  sled_pkg::mode_e mode_q, mode_d;
  logic [20:0]     acc_q, acc_d;
  logic [3:0]      dig_q, dig_d;
  logic [1:0]      left_q, left_d;
  logic [2:0]      len_q, len_d;
  logic            err_seen_q, err_seen_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= sled_pkg::MODE_PLAIN;
      acc_q      <= '0;
      dig_q      <= '0;
      left_q     <= '0;
      len_q      <= '0;
      err_seen_q <= 1'b0;
    end else if (accept_i) begin
      mode_q     <= mode_d;
      acc_q      <= acc_d;
      dig_q      <= dig_d;
      left_q     <= left_d;
      len_q      <= len_d;
      err_seen_q <= err_seen_d;
    end
  end

  logic [7:0]  b;
  logic        e0, e1, endv, failed, fresh, dat_ok;
  logic [3:0]  c0, c1;
  logic [4:0]  hx;
  logic [3:0]  dig_inc;
  logic [20:0] acc_t;
  logic [24:0] wide;
  logic        bad;
  enc_t        enc;
  logic [2:0]  n;

  always_comb begin
    b          = item_i.in_byte;
    mode_d     = mode_q;
    acc_d      = acc_q;
    dig_d      = dig_q;
    left_d     = left_q;
    len_d      = len_q;
    err_seen_d = err_seen_q;
    e0         = 1'b0;
    e1         = 1'b0;
    c0         = sled_pkg::ERR_NONE;
    c1         = sled_pkg::ERR_NONE;
    endv       = 1'b0;
    failed     = 1'b0;
    fresh      = 1'b0;
    enc        = '0;
    hx         = hex_of(b);
    dig_inc    = dig_q + 4'd1;
    acc_t      = '0;
    wide       = '0;
    bad        = 1'b0;

    if (item_i.end_of_literal) begin
      e0     = (mode_q != sled_pkg::MODE_PLAIN);
      c0     = sled_pkg::ERR_UNFIN;
      endv   = 1'b1;
      failed = err_seen_q | e0;
      mode_d = sled_pkg::MODE_PLAIN;
      acc_d  = '0;
      dig_d  = '0;
      left_d = '0;
      len_d  = '0;
    end else begin
      case (mode_q)
        sled_pkg::MODE_ESC: begin
          mode_d = sled_pkg::MODE_PLAIN;
          acc_d  = '0;
          dig_d  = '0;
          left_d = '0;
          len_d  = '0;
          enc.n  = 3'd1;
          case (b)
            8'h61:   enc.b[0] = 8'h07;
            8'h62:   enc.b[0] = 8'h08;
            8'h65:   enc.b[0] = 8'h1B;
            8'h66:   enc.b[0] = 8'h0C;
            8'h6E:   enc.b[0] = 8'h0A;
            8'h72:   enc.b[0] = 8'h0D;
            8'h74:   enc.b[0] = 8'h09;
            8'h76:   enc.b[0] = 8'h0B;
            8'h22, 8'h27, 8'h5C, 8'h3F: enc.b[0] = b;
            8'h30:   enc.b[0] = 8'h00;
            8'h6F: begin
              enc.n  = 3'd0;
              mode_d = sled_pkg::MODE_OCT;
            end
            8'h78: begin
              enc.n  = 3'd0;
              mode_d = sled_pkg::MODE_HEXX;
            end
            8'h75: begin
              enc.n  = 3'd0;
              mode_d = sled_pkg::MODE_UNI4;
            end
            8'h55: begin
              enc.n  = 3'd0;
              mode_d = sled_pkg::MODE_UNI8;
            end
            default: begin
              enc.n = 3'd0;
              e0    = 1'b1;
              c0    = sled_pkg::ERR_ESCAPE;
            end
          endcase
        end
        sled_pkg::MODE_OCT: begin
          if (!(b inside {[8'h30:8'h37]})) begin
            e0    = 1'b1;
            c0    = sled_pkg::ERR_OCT_DIG;
            fresh = 1'b1;
          end else begin
            acc_t = {acc_q[17:0], b[2:0]};
            acc_d = acc_t;
            dig_d = dig_inc;
            if (dig_inc >= 4'd3) begin
              mode_d = sled_pkg::MODE_PLAIN;
              acc_d  = '0;
              dig_d  = '0;
              if (acc_t > 21'hFF) begin
                e0 = 1'b1;
                c0 = sled_pkg::ERR_OCT_OVER;
              end else begin
                enc.n    = 3'd1;
                enc.b[0] = acc_t[7:0];
              end
            end
          end
        end
        sled_pkg::MODE_HEXX: begin
          if (!hx[4]) begin
            e0    = 1'b1;
            c0    = sled_pkg::ERR_HEX_DIG;
            fresh = 1'b1;
          end else begin
            acc_t = {13'd0, acc_q[3:0], hx[3:0]};
            acc_d = acc_t;
            dig_d = dig_inc;
            if (dig_inc >= 4'd2) begin
              mode_d   = sled_pkg::MODE_PLAIN;
              acc_d    = '0;
              dig_d    = '0;
              enc.n    = 3'd1;
              enc.b[0] = acc_t[7:0];
            end
          end
        end
        sled_pkg::MODE_UNI4, sled_pkg::MODE_UNI8: begin
          if (!hx[4]) begin
            e0    = 1'b1;
            c0    = (mode_q == sled_pkg::MODE_UNI8) ? sled_pkg::ERR_SHORT_U8
                                                    : sled_pkg::ERR_SHORT_U4;
            fresh = 1'b1;
          end else begin
            wide  = {acc_q, hx[3:0]};
            // saturate once out of range so later digits cannot wrap back
            acc_t = (wide > {4'd0, sled_pkg::CpMax}) ? 21'h1FFFFF : wide[20:0];
            acc_d = acc_t;
            dig_d = dig_inc;
            if (dig_inc >= ((mode_q == sled_pkg::MODE_UNI8) ? 4'd8 : 4'd4)) begin
              mode_d = sled_pkg::MODE_PLAIN;
              acc_d  = '0;
              dig_d  = '0;
              if (acc_t > sled_pkg::CpMax) begin
                e0 = 1'b1;
                c0 = sled_pkg::ERR_RANGE;
              end else begin
                enc = utf8_enc(acc_t);
              end
            end
          end
        end
        sled_pkg::MODE_UTF8: begin
          if (b[7:6] != 2'b10) begin
            e0    = 1'b1;
            c0    = sled_pkg::ERR_UTF8;
            fresh = 1'b1;
          end else begin
            acc_t = {acc_q[14:0], b[5:0]};
            acc_d = acc_t;
            if (left_q > 2'd1) begin
              left_d = left_q - 2'd1;
            end else begin
              mode_d = sled_pkg::MODE_PLAIN;
              acc_d  = '0;
              dig_d  = '0;
              left_d = '0;
              len_d  = '0;
              if (len_q == 3'd2) begin
                bad = acc_t < 21'h80;
              end else if (len_q == 3'd3) begin
                bad = (acc_t < 21'h800) || (acc_t inside {[21'hD800:21'hDFFF]});
              end else begin
                bad = (acc_t < 21'h10000) || (acc_t > sled_pkg::CpMax);
              end
              if (bad) begin
                e0 = 1'b1;
                c0 = sled_pkg::ERR_UTF8;
              end else begin
                enc = utf8_enc(acc_t);
              end
            end
          end
        end
        default: fresh = 1'b1;
      endcase

      // start of a new character, also after a byte that broke a sequence
      if (fresh) begin
        mode_d = sled_pkg::MODE_PLAIN;
        acc_d  = '0;
        dig_d  = '0;
        left_d = '0;
        len_d  = '0;
        if (b == 8'h5C) begin
          mode_d = sled_pkg::MODE_ESC;
        end else if (!b[7]) begin
          enc.n    = 3'd1;
          enc.b[0] = b;
        end else if (b[7:5] == 3'b110) begin
          acc_d  = {16'd0, b[4:0]};
          left_d = 2'd1;
          len_d  = 3'd2;
          mode_d = sled_pkg::MODE_UTF8;
        end else if (b[7:4] == 4'b1110) begin
          acc_d  = {17'd0, b[3:0]};
          left_d = 2'd2;
          len_d  = 3'd3;
          mode_d = sled_pkg::MODE_UTF8;
        end else if (b[7:3] == 5'b11110) begin
          acc_d  = {18'd0, b[2:0]};
          left_d = 2'd3;
          len_d  = 3'd4;
          mode_d = sled_pkg::MODE_UTF8;
        end else if (e0) begin
          e1 = 1'b1;
          c1 = sled_pkg::ERR_UTF8;
        end else begin
          e0 = 1'b1;
          c0 = sled_pkg::ERR_UTF8;
        end
      end
      err_seen_d = err_seen_q | e0 | e1;
    end

    if (item_i.end_of_literal) begin
      err_seen_d = 1'b0;
    end

    // data is dropped once the literal has seen an error
    dat_ok = !(err_seen_q | e0 | e1);

    run_o = '0;
    n     = '0;
    if (e0) begin
      run_o.slot[n[1:0]].out_kind   = sled_pkg::KIND_ERR;
      run_o.slot[n[1:0]].error_code = c0;
      n = n + 3'd1;
    end
    if (e1) begin
      run_o.slot[n[1:0]].out_kind   = sled_pkg::KIND_ERR;
      run_o.slot[n[1:0]].error_code = c1;
      n = n + 3'd1;
    end
    if (dat_ok && !endv) begin
      for (int i = 0; i < sled_pkg::MaxRes; i++) begin
        if (3'(i) < enc.n) begin
          run_o.slot[i].out_kind = sled_pkg::KIND_DATA;
          run_o.slot[i].out_byte = enc.b[i];
        end
      end
      n = enc.n;
    end
    if (endv) begin
      run_o.slot[n[1:0]].out_kind       = sled_pkg::KIND_END;
      run_o.slot[n[1:0]].literal_failed = failed;
      n = n + 3'd1;
    end
    if (n != 3'd0) begin
      run_o.slot[2'(n - 3'd1)].last_of_run = 1'b1;
    end
    run_o.cnt = n;
  end

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.end_of_literal |=> mode_q == sled_pkg::MODE_PLAIN && !err_seen_q)
    else $error("decode state not cleared after end of literal");
`endif

endmodule

### src/sled_outbuf.sv
// ----------------------------------------------------------------------------
// sled_outbuf
// result register: holds one item's results and, while the output is not stalled, sends them one per cycle
// ----------------------------------------------------------------------------
module sled_outbuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  sled_pkg::run_t  run_i,
  output logic            free_o,
  output logic            out_valid_o,
  output sled_pkg::out_t  out_item_o,
  input  logic            out_stall_i
);

  sled_pkg::out_t [sled_pkg::MaxRes-1:0] slot_q;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_item_o  = slot_q[idx_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign free_o      = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && !out_stall_i);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = run_i.cnt;
      idx_d = '0;
    end else if (pop) begin
      cnt_d = cnt_q - 3'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= run_i.slot;
    end
  end

endmodule

### src/string_literal_escape_decoder_top.sv
// ----------------------------------------------------------------------------
// string_literal_escape_decoder_top
// utf-8 checking and escape expanding decoder for quoted literal bodies
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | item
//  --------+-----------+--------------------------+-------------------------
//  in      | input     | in_valid_i / in_stall_o  | sled_pkg::in_t, one byte
//  out     | output    | out_valid_o / out_stall_i| sled_pkg::out_t, 1 result
//
// one input item per cycle while in_stall_o is low; the decode is single pass into the result register
// an item that yields several results holds the input side until its last result is on
//   the port and not stalled; the result register sends one result per cycle while out_stall_i is low
// items that yield no result (escape lead, partial digit or utf-8 runs) still need
//   the result register to be free
// reset clears decode state and the result register, no clearing pass
// a stalled output holds its item; in_stall_o also follows out_stall_i when
//   the last pending result is on the port
module string_literal_escape_decoder_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  sled_pkg::in_t   in_item_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output sled_pkg::out_t  out_item_o,
  input  logic            out_stall_i
);

  logic           free;
  logic           accept;
  sled_pkg::run_t run;

  // an item enters only when the result register can take its results
  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  // decode state and result generation
  sled_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .run_o    (run)
  );

  // result register and output sequencing
  sled_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .run_i       (run),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

`ifndef SYNTHESIS
  // empty result register never holds the input off
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // an end of literal always produces a result in the next cycle
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.end_of_literal |=> out_valid_o)
    else $error("no result after end of literal");

  // taking the final result of a run frees the input side
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_item_o.last_of_run |-> !in_stall_o)
    else $error("input still stalled after last result of a run");
`endif

endmodule

### verif/sled_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sled_tb_pkg
// decode predictor and result scoreboard for the literal escape decoder bench
// ----------------------------------------------------------------------------
package sled_tb_pkg;

  import sled_pkg::*;

  class decode_scoreboard;
    mode_e       mode;
    logic [20:0] acc;
    int unsigned digits;
    int unsigned utf8_left;
    int unsigned utf8_len;
    bit          lit_error;
    out_t        run[$];
    out_t        expected_q[$];
    int unsigned mismatches;

    function new();
      clear_seq();
      lit_error  = 1'b0;
      mismatches = 0;
    endfunction

    function void clear_seq();
      mode      = MODE_PLAIN;
      acc       = '0;
      digits    = 0;
      utf8_left = 0;
      utf8_len  = 0;
    endfunction

    function void add(logic [1:0] kind, logic [7:0] data, logic [3:0] code, logic failed);
      out_t r;
      if (run.size() >= MaxRes) return;
      r.out_kind       = kind;
      r.out_byte       = data;
      r.error_code     = code;
      r.literal_failed = failed;
      r.last_of_run    = 1'b0;
      run.push_back(r);
    endfunction

    // data is dropped once the literal has failed
    function void add_data(logic [7:0] data);
      if (!lit_error) add(KIND_DATA, data, ERR_NONE, 1'b0);
    endfunction

    function void add_error(logic [3:0] code);
      lit_error = 1'b1;
      add(KIND_ERR, 8'h00, code, 1'b0);
    endfunction

    function int hex_value(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      return 16;
    endfunction

    function void encode(logic [20:0] cp);
      if (cp <= 21'h7F) begin
        add_data(cp[7:0]);
      end else if (cp <= 21'h7FF) begin
        add_data({3'b110, cp[10:6]});
        add_data({2'b10, cp[5:0]});
      end else if (cp <= 21'hFFFF) begin
        add_data({4'b1110, cp[15:12]});
        add_data({2'b10, cp[11:6]});
        add_data({2'b10, cp[5:0]});
      end else begin
        add_data({5'b11110, cp[20:18]});
        add_data({2'b10, cp[17:12]});
        add_data({2'b10, cp[11:6]});
        add_data({2'b10, cp[5:0]});
      end
    endfunction

    function void fresh(logic [7:0] b);
      clear_seq();
      if (b == "\\") begin
        mode = MODE_ESC;
      end else if (!b[7]) begin
        add_data(b);
      end else if (b[7:5] == 3'b110) begin
        acc = {16'h0, b[4:0]};
        utf8_left = 1;
        utf8_len  = 2;
        mode      = MODE_UTF8;
      end else if (b[7:4] == 4'b1110) begin
        acc = {17'h0, b[3:0]};
        utf8_left = 2;
        utf8_len  = 3;
        mode      = MODE_UTF8;
      end else if (b[7:3] == 5'b11110) begin
        acc = {18'h0, b[2:0]};
        utf8_left = 3;
        utf8_len  = 4;
        mode      = MODE_UTF8;
      end else begin
        add_error(ERR_UTF8);
      end
    endfunction

    function void escape(logic [7:0] b);
      logic [7:0] v;
      clear_seq();
      case (b)
        "a":  v = 8'h07;
        "b":  v = 8'h08;
        "e":  v = 8'h1B;
        "f":  v = 8'h0C;
        "n":  v = 8'h0A;
        "r":  v = 8'h0D;
        "t":  v = 8'h09;
        "v":  v = 8'h0B;
        "\"": v = "\"";
        "'":  v = "'";
        "0":  v = 8'h00;
        "\\": v = "\\";
        "?":  v = "?";
        "o": begin
          mode = MODE_OCT;
          return;
        end
        "x": begin
          mode = MODE_HEXX;
          return;
        end
        "u": begin
          mode = MODE_UNI4;
          return;
        end
        "U": begin
          mode = MODE_UNI8;
          return;
        end
        default: begin
          add_error(ERR_ESCAPE);
          return;
        end
      endcase
      add_data(v);
    endfunction

    function void take_byte(logic [7:0] b);
      int          d;
      logic [31:0] wide;
      logic [20:0] cp;
      int unsigned len;
      bit          bad;
      case (mode)
        MODE_ESC: escape(b);
        MODE_OCT: begin
          if (b < "0" || b > "7") begin
            add_error(ERR_OCT_DIG);
            fresh(b);
          end else begin
            acc = {acc[17:0], b[2:0]};
            digits++;
            if (digits >= 3) begin
              cp = acc;
              clear_seq();
              if (cp > 21'hFF) add_error(ERR_OCT_OVER);
              else add_data(cp[7:0]);
            end
          end
        end
        MODE_HEXX: begin
          d = hex_value(b);
          if (d > 15) begin
            add_error(ERR_HEX_DIG);
            fresh(b);
          end else begin
            acc = {13'h0, acc[3:0], d[3:0]};
            digits++;
            if (digits >= 2) begin
              cp = acc;
              clear_seq();
              add_data(cp[7:0]);
            end
          end
        end
        MODE_UNI4, MODE_UNI8: begin
          d = hex_value(b);
          if (d > 15) begin
            add_error((mode == MODE_UNI8) ? ERR_SHORT_U8 : ERR_SHORT_U4);
            fresh(b);
          end else begin
            // saturate once past the code space
            wide = {7'h0, acc, d[3:0]};
            acc  = (wide > 32'h10FFFF) ? 21'h1FFFFF : wide[20:0];
            digits++;
            if (digits >= ((mode == MODE_UNI8) ? 8 : 4)) begin
              cp = acc;
              clear_seq();
              if (cp > CpMax) add_error(ERR_RANGE);
              else encode(cp);
            end
          end
        end
        MODE_UTF8: begin
          if (b[7:6] != 2'b10) begin
            add_error(ERR_UTF8);
            fresh(b);
          end else begin
            acc = {acc[14:0], b[5:0]};
            if (utf8_left > 1) begin
              utf8_left--;
            end else begin
              cp  = acc;
              len = utf8_len;
              clear_seq();
              if (len == 2) bad = cp < 21'h80;
              else if (len == 3) bad = cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF);
              else bad = cp < 21'h10000 || cp > CpMax;
              if (bad) add_error(ERR_UTF8);
              else encode(cp);
            end
          end
        end
        default: fresh(b);
      endcase
    endfunction

    // accepted input item: work out its results and queue them
    function void note_item(in_t it);
      out_t r;
      run.delete();
      if (it.end_of_literal) begin
        if (mode != MODE_PLAIN) add_error(ERR_UNFIN);
        add(KIND_END, 8'h00, ERR_NONE, lit_error);
        clear_seq();
        lit_error = 1'b0;
      end else begin
        take_byte(it.in_byte);
      end
      if (run.size() > 0) begin
        r = run.pop_back();
        r.last_of_run = 1'b1;
        run.push_back(r);
      end
      foreach (run[i]) expected_q.push_back(run[i]);
    endfunction

    function string describe(out_t r);
      return $sformatf("kind %0d byte %02h code %0d failed %b last %b",
                       r.out_kind, r.out_byte, r.error_code, r.literal_failed, r.last_of_run);
    endfunction

    // accepted result: compare with the oldest expected one
    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", describe(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
          got.error_code !== want.error_code || got.literal_failed !== want.literal_failed ||
          got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result differs at %0t", $time);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// bench for the string literal escape decoder: directed and random literals
// are streamed in, every accepted byte is run through a predictor, and every
// accepted result is checked in order against the predicted results
// ----------------------------------------------------------------------------
module tb_top;

  import sled_pkg::*;
  import sled_tb_pkg::*;

  localparam int unsigned HoldCycles  = 300;      // long receiver hold-off
  localparam int unsigned DrainCycles = 20;       // quiet time after last result
  localparam int unsigned RandomItems = 75;       // per idling phase
  localparam int unsigned RunLimitNs  = 5000000;

  // single-letter escapes the decoder knows, packed one per byte
  localparam logic [103:0] EscLetters = "abefnrtv\"'0\\?";

  logic  clk_i;
  logic  rst_ni       = 1'b0;
  logic  in_valid_i   = 1'b0;
  in_t   in_item_i    = '0;
  logic  in_stall_o;
  logic  out_valid_o;
  out_t  out_item_o;
  logic  out_stall_i  = 1'b0;

  // idling knobs, in percent of cycles
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // bumped by the main sequence, served by the receiver process
  int unsigned hold_requests  = 0;

  decode_scoreboard sb;
  in_t              stim_q[$];

  string_literal_escape_decoder_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // stimulus building: items are queued per phase and then streamed
  // ---------------------------------------------------------------------------

  function automatic void put(logic [7:0] b);
    in_t it;
    it.in_byte        = b;
    it.end_of_literal = 1'b0;
    stim_q.push_back(it);
  endfunction

  // closing quote; the byte beside it is don't-care, so randomize it
  function automatic void put_end();
    in_t it;
    it.in_byte        = 8'($urandom_range(255));
    it.end_of_literal = 1'b1;
    stim_q.push_back(it);
  endfunction

  // hex digit with random letter case
  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return "0" + {4'h0, v};
    if ($urandom_range(1) == 0) return "a" + {4'h0, v} - 8'd10;
    return "A" + {4'h0, v} - 8'd10;
  endfunction

  function automatic void put_hex(logic [31:0] v, int unsigned n);
    int i;
    for (i = int'(n) - 1; i >= 0; i--) put(hex_char(v[4*i +: 4]));
  endfunction

  // utf-8 form of forced length, so overlong and out-of-range forms can be made
  function automatic void put_utf8(logic [20:0] cp, int unsigned len);
    case (len)
      2: begin
        put({3'b110, cp[10:6]});
        put({2'b10, cp[5:0]});
      end
      3: begin
        put({4'b1110, cp[15:12]});
        put({2'b10, cp[11:6]});
        put({2'b10, cp[5:0]});
      end
      default: begin
        put({5'b11110, cp[20:18]});
        put({2'b10, cp[17:12]});
        put({2'b10, cp[11:6]});
        put({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // one well-formed multi-byte construct; returns how many trailing bytes
  // may be cut off to make a broken one
  function automatic int unsigned put_seq(int unsigned which);
    int unsigned len;
    int unsigned tail;
    logic [20:0] cp;
    logic [31:0] v;
    case (which)
      0: begin
        // octal: half the time the lead digit keeps it in range
        put("\\");
        put("o");
        put(8'("0" + (($urandom_range(1) == 0) ? $urandom_range(3) : $urandom_range(7))));
        put(8'("0" + $urandom_range(7)));
        put(8'("0" + $urandom_range(7)));
        tail = 3;
      end
      1: begin
        put("\\");
        put("x");
        put_hex($urandom_range(255), 2);
        tail = 2;
      end
      2: begin
        // short unicode escape, often naming a surrogate
        put("\\");
        put("u");
        v = ($urandom_range(3) == 0) ? $urandom_range(32'hDFFF, 32'hD800)
                                     : $urandom_range(32'hFFFF);
        put_hex(v, 4);
        tail = 4;
      end
      3: begin
        // long unicode escape around and beyond the top of the code space
        put("\\");
        put("U");
        case ($urandom_range(3))
          0:       v = $urandom;
          1:       v = 32'h10FFF0 + $urandom_range(31);
          default: v = $urandom_range(32'h10FFFF);
        endcase
        put_hex(v, 8);
        tail = 8;
      end
      default: begin
        // valid utf-8 of random length
        len = $urandom_range(4, 2);
        case (len)
          2: cp = 21'($urandom_range(32'h7FF, 32'h80));
          3: begin
            cp = 21'($urandom_range(32'hFFFF, 32'h800));
            if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
          end
          default: cp = 21'($urandom_range(32'h10FFFF, 32'h10000));
        endcase
        put_utf8(cp, len);
        tail = len - 1;
      end
    endcase
    return tail;
  endfunction

  function automatic void put_token();
    int unsigned pick;
    int unsigned k;
    int unsigned cut;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 20) begin
      // plain ascii, control bytes included
      b = 8'($urandom_range(127));
      if (b == "\\") b = "z";
      put(b);
    end else if (pick < 30) begin
      k = $urandom_range(12);
      put("\\");
      put(EscLetters[8*k +: 8]);
    end else if (pick < 34) begin
      // escape with any byte, mostly unknown ones
      put("\\");
      put(8'($urandom_range(255)));
    end else if (pick < 66) begin
      void'(put_seq($urandom_range(4)));
    end else if (pick < 74) begin
      void'(put_seq(4));
    end else if (pick < 84) begin
      // malformed utf-8: overlong, surrogate, or past the code space
      case ($urandom_range(2))
        0:       put_utf8(21'($urandom_range(127)), $urandom_range(4, 2));
        1:       put_utf8(21'($urandom_range(32'hDFFF, 32'hD800)), 3);
        default: put_utf8(21'($urandom_range(32'h1FFFFF, 32'h110000)), 4);
      endcase
    end else if (pick < 94) begin
      // broken construct: cut short, then maybe a stray byte interrupts it
      cut = put_seq($urandom_range(4));
      repeat ($urandom_range(cut, 1)) void'(stim_q.pop_back());
      if ($urandom_range(1) == 0) put(8'($urandom_range(255)));
    end else begin
      put(8'($urandom_range(255)));
    end
  endfunction

  // whole literals until the item count is reached
  function automatic void add_random(int unsigned count);
    int unsigned target;
    target = stim_q.size() + count;
    while (stim_q.size() < target) begin
      repeat ($urandom_range(10)) put_token();
      put_end();
    end
  endfunction

  function automatic void load_directed();
    // good literal: zero and newline bytes, top code point, top octal value
    put(8'h00);
    put(8'h0A);
    put_utf8(CpMax, 4);
    put("\\"); put("o"); put("3"); put("7"); put("7");
    put_end();
    // failing literal: octal over range, bad second hex digit, bad lead byte,
    // overlong form, and an escape left open at the closing quote
    put("\\"); put("o"); put("4"); put("0"); put("0");
    put("\\"); put("x"); put("4"); put("g");
    put(8'hFF);
    put_utf8(21'h0, 3);
    put("\\"); put("u");
    put_end();
  endfunction

  // ---------------------------------------------------------------------------
  // input side driver
  // ---------------------------------------------------------------------------

  // random idle gap, then hold the item until it is taken
  task automatic send_item(input in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_all();
    while (stim_q.size() != 0) send_item(stim_q.pop_front());
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stall, plus a long hold-off when one is requested
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned holds_done;
    int unsigned k;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_done) begin
        holds_done++;
        for (k = 0; k < HoldCycles; k++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: both handshakes are sampled at the edge where they complete
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_item(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender mostly busy, receiver mostly stalled
    send_idle_pct  = 9;
    recv_stall_pct = 88;
    load_directed();
    send_all();
    add_random(RandomItems);
    send_all();

    // sender mostly idle, receiver mostly ready
    send_idle_pct  = 88;
    recv_stall_pct = 9;
    add_random(RandomItems);
    send_all();

    // full rate both sides, opened by a long receiver hold-off so the
    // block backs up into its input
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    add_random(RandomItems);
    send_all();
    in_valid_i <= 1'b0;

    // let every predicted result arrive, then watch for strays
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("string_literal_escape_decoder_top: match");
    end else begin
      $display("string_literal_escape_decoder_top: mismatch");
    end
    $finish;
  end

  // run limit, well beyond the slowest legal run
  initial begin
    #(RunLimitNs);
    $display("string_literal_escape_decoder_top: mismatch");
    $finish;
  end

endmodule
